// ===== rtl/core/hps_pkg.sv =====
// hps_pkg: types, role codes, recipe constants and fixed-point helpers for the HSV shade core.
// Used by hsv_pixel_shade_core and the bench. No dependencies.
`timescale 1ns / 1ps

package hps_pkg;

	typedef struct packed {
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [1:0]  role;
		logic [16:0] shade_amount;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// role codes; the spare code behaves as edge
	localparam logic [1:0] ROLE_TERRAIN_A = 2'd0;
	localparam logic [1:0] ROLE_TERRAIN_B = 2'd1;
	localparam logic [1:0] ROLE_EDGE      = 2'd2;
	localparam logic [1:0] ROLE_SPARE     = 2'd3;

	// per-role recipes, Q0.16; role code 3 behaves as edge
	localparam logic [15:0] HUE_SHIFT [4] = '{16'd0, 16'd789, 16'd0, 16'd0};
	localparam logic [15:0] GREY_HUE  [4] = '{16'd35499, 16'd789, 16'd0, 16'd0};
	localparam logic [15:0] SAT_ADD   [4] = '{16'd8456, 16'd10923, 16'd0, 16'd0};
	localparam logic [15:0] VAL_DROP  [4] = '{16'd0, 16'd7282, 16'd0, 16'd0};

	// rounded Q16 product
	function automatic logic [17:0] rmul(input logic [16:0] a, input logic [16:0] b);
		logic [33:0] p;
		p = 34'(a) * 34'(b) + 34'd32768;
		return p[33:16];
	endfunction

	// Q1.16 to byte, round half up, clamped
	function automatic logic [7:0] to_byte(input logic [16:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd255 + 26'd32768;
		return (p[25:16] > 10'd255) ? 8'd255 : p[23:16];
	endfunction

endpackage

// ===== rtl/core/hps_div_pipe.sv =====
// hps_div_pipe: pipelined restoring divider, one quotient bit per register stage.
// Stages advance only under en. Requires num < den * 2**QW. Uses no package.
`timescale 1ns / 1ps

module hps_div_pipe #(
	parameter int NW = 25,
	parameter int DW = 8,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int WW = DW + QW;

	logic [WW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int J = QW - 1 - i;
		logic [WW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [WW-1:0] dsh;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = WW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign dsh = WW'(den_in) << J;
		assign ge  = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rem_in - dsh : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= quo_in | (ge ? (QW'(1) << J) : QW'(0));
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

// ===== rtl/core/hsv_pixel_shade_core.sv =====
// hsv_pixel_shade_core: RGB -> HSV, per-role hue/saturation/value shade, HSV -> RGB.
// Depends on hps_pkg and hps_div_pipe.
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------
//  src     | src_valid, src_ready, src_pixel  | hps_pkg::pix_in_t
//  dst     | dst_valid, dst_ready, dst_pixel  | hps_pkg::pix_out_t
//
// One pixel per cycle unless dst stalls; the pipeline is one input stage, 17 divider stages
// (saturation and hue quotients, one bit per stage) and five shading/output stages.
// The whole pipeline holds while dst is stalled; src_ready is low only then.
// arst_n clears the valid bits alone; data registers carry no reset.
`timescale 1ns / 1ps

module hsv_pixel_shade_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  hps_pkg::pix_in_t   src_pixel,
	output logic               dst_valid,
	input  logic               dst_ready,
	output hps_pkg::pix_out_t  dst_pixel
);

	localparam int QW  = 17;
	localparam int LAT = QW + 6;

	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [1:0]  role;
		logic [16:0] t;
		logic [16:0] v0;
		logic        dz;
	} side_t;

	logic [LAT-1:0] vld_q;
	logic           adv;

	assign adv       = !vld_q[LAT-1] || dst_ready;
	assign src_ready = adv;
	assign dst_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], src_valid};
		end
	end

	// input stage: extremes, hue numerator, divider operands
	logic [7:0]  r, g, b, mx, mn, d;
	logic [16:0] t_c;
	logic [11:0] num_w;

	always_comb begin
		r   = src_pixel.red_in;
		g   = src_pixel.green_in;
		b   = src_pixel.blue_in;
		t_c = (src_pixel.shade_amount > hps_pkg::ONE_Q16) ? hps_pkg::ONE_Q16
			: src_pixel.shade_amount;
		mx  = (r > g) ? r : g;
		if (b > mx) mx = b;
		mn  = (r < g) ? r : g;
		if (b < mn) mn = b;
		d   = mx - mn;
		if (r == mx) begin
			num_w = (g >= b) ? 12'(g) - 12'(b) : 12'(d) * 12'd6 + 12'(g) - 12'(b);
		end else if (g == mx) begin
			num_w = 12'(d) * 12'd2 + 12'(b) - 12'(r);
		end else begin
			num_w = 12'(d) * 12'd4 + 12'(r) - 12'(g);
		end
	end

	side_t       side_s1;
	logic [24:0] sn_s1;
	logic [7:0]  sd_s1;
	logic [26:0] hn_s1;
	logic [10:0] hd_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.r    <= r;
			side_s1.g    <= g;
			side_s1.b    <= b;
			side_s1.role <= src_pixel.role;
			side_s1.t    <= t_c;
			// mx*65536/255 rounded: 65536 = 255*257 + 1
			side_s1.v0   <= 17'(mx) * 17'd257 + {16'd0, mx[7]};
			side_s1.dz   <= (d == 8'd0);
			sn_s1        <= {1'b0, d, 16'd0} + 25'(mx >> 1);
			sd_s1        <= mx;
			hn_s1        <= {num_w[10:0], 16'd0} + 27'(d) * 27'd3;
			hd_s1        <= 11'(d) * 11'd6;
		end
	end

	logic [QW-1:0] s_quo, h_quo;

	hps_div_pipe #(.NW(25), .DW(8), .QW(QW)) u_div_sat (
		.clk(clk), .en(adv), .num(sn_s1), .den(sd_s1), .quo(s_quo)
	);

	hps_div_pipe #(.NW(27), .DW(11), .QW(QW)) u_div_hue (
		.clk(clk), .en(adv), .num(hn_s1), .den(hd_s1), .quo(h_quo)
	);

	side_t side_dly [QW];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly[0] <= side_s1;
			for (int i = 1; i < QW; i++) side_dly[i] <= side_dly[i-1];
		end
	end

	// stage A: recipe terms
	side_t       sd;
	logic [17:0] hs, sa, vd, s_sum;

	assign sd    = side_dly[QW-1];
	assign hs    = hps_pkg::rmul(17'(hps_pkg::HUE_SHIFT[sd.role]), sd.t);
	assign sa    = hps_pkg::rmul(17'(hps_pkg::SAT_ADD[sd.role]), sd.t);
	assign vd    = hps_pkg::rmul(17'(hps_pkg::VAL_DROP[sd.role]), sd.t);
	assign s_sum = (sd.dz ? 18'd0 : 18'(s_quo)) + sa;

	logic [23:0] rgb_a, rgb_b, rgb_c, rgb_d;
	logic        pass_a, pass_b, pass_c, pass_d;
	logic [15:0] h_a;
	logic [16:0] s_a, v0_a, vf_a;

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_a  <= {sd.r, sd.g, sd.b};
			pass_a <= (sd.t == 17'd0);
			h_a    <= sd.dz ? hps_pkg::GREY_HUE[sd.role] : h_quo[15:0] + hs[15:0];
			s_a    <= (s_sum > 18'(hps_pkg::ONE_Q16)) ? hps_pkg::ONE_Q16 : s_sum[16:0];
			v0_a   <= sd.v0;
			vf_a   <= hps_pkg::ONE_Q16 - vd[16:0];
		end
	end

	// stage B: value scale, sextant
	logic [17:0] vv;
	logic [18:0] h6;
	logic [16:0] v_b, s_b;
	logic [2:0]  sec_b;
	logic [15:0] f_b;

	assign vv = hps_pkg::rmul(v0_a, vf_a);
	assign h6 = 19'(h_a) * 19'd6;

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_b  <= rgb_a;
			pass_b <= pass_a;
			v_b    <= (vv > 18'(hps_pkg::ONE_Q16)) ? hps_pkg::ONE_Q16 : vv[16:0];
			s_b    <= s_a;
			sec_b  <= h6[18:16];
			f_b    <= h6[15:0];
		end
	end

	// stage C: p and the saturation-fraction products
	logic [17:0] p_w, sf_w, sf1_w;
	logic [16:0] v_c, s_c, p_c, sf_c, sf1_c;
	logic [2:0]  sec_c;

	assign p_w   = hps_pkg::rmul(v_b, hps_pkg::ONE_Q16 - s_b);
	assign sf_w  = hps_pkg::rmul(s_b, {1'b0, f_b});
	assign sf1_w = hps_pkg::rmul(s_b, hps_pkg::ONE_Q16 - {1'b0, f_b});

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_c  <= rgb_b;
			pass_c <= pass_b;
			v_c    <= v_b;
			s_c    <= s_b;
			sec_c  <= sec_b;
			p_c    <= p_w[16:0];
			sf_c   <= sf_w[16:0];
			sf1_c  <= sf1_w[16:0];
		end
	end

	// stage D: q and t
	logic [17:0] q_w, tt_w;
	logic [16:0] v_d, p_d, q_d, tt_d;
	logic [2:0]  sec_d;
	logic        grey_d;

	assign q_w  = hps_pkg::rmul(v_c, hps_pkg::ONE_Q16 - sf_c);
	assign tt_w = hps_pkg::rmul(v_c, hps_pkg::ONE_Q16 - sf1_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_d  <= rgb_c;
			pass_d <= pass_c;
			v_d    <= v_c;
			p_d    <= p_c;
			q_d    <= q_w[16:0];
			tt_d   <= tt_w[16:0];
			sec_d  <= sec_c;
			grey_d <= (s_c == 17'd0);
		end
	end

	// stage E: sextant select, bytes or pass-through, output register
	logic [16:0] x, y, z;

	always_comb begin
		unique case (sec_d)
			3'd0:    begin x = v_d;  y = tt_d; z = p_d;  end
			3'd1:    begin x = q_d;  y = v_d;  z = p_d;  end
			3'd2:    begin x = p_d;  y = v_d;  z = tt_d; end
			3'd3:    begin x = p_d;  y = q_d;  z = v_d;  end
			3'd4:    begin x = tt_d; y = p_d;  z = v_d;  end
			default: begin x = v_d;  y = p_d;  z = q_d;  end
		endcase
		if (grey_d) begin
			x = v_d;
			y = v_d;
			z = v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pass_d) begin
				dst_pixel <= rgb_d;
			end else begin
				dst_pixel.red_out   <= hps_pkg::to_byte(x);
				dst_pixel.green_out <= hps_pkg::to_byte(y);
				dst_pixel.blue_out  <= hps_pkg::to_byte(z);
			end
		end
	end

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valids moved during a stall");

	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[LAT-2] |=> dst_valid)
		else $error("request lost at the output register");

	a_sextant: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[QW+2] |-> sec_b <= 3'd5)
		else $error("hue sextant out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[QW+1] |-> s_a <= hps_pkg::ONE_Q16)
		else $error("saturation above one");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for hsv_pixel_shade_core (RGB -> HSV shade -> RGB).
// Depends on hps_pkg and hsv_pixel_shade_core; holds its own bit-exact predictor.
`timescale 1ns / 1ps

class shade_board;
	hps_pkg::pix_out_t pending[$];
	int errors;
	int checked;

	function logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b) + 64'd32768;
		return p[47:16];
	endfunction

	function logic [7:0] byte_of(logic [31:0] x);
		logic [63:0] y;
		y = (64'(x) * 64'd255 + 64'd32768) >> 16;
		return (y > 64'd255) ? 8'd255 : y[7:0];
	endfunction

	function hps_pkg::pix_out_t shade(hps_pkg::pix_in_t px);
		logic [31:0] r, g, b, amt, mx, mn, d, v, s, h, h0, num, h6, sec, f, p, q, tt;
		logic [31:0] shift_k, grey_k, sat_k, drop_k, x, y, z;
		hps_pkg::pix_out_t o;
		r = 32'(px.red_in); g = 32'(px.green_in); b = 32'(px.blue_in);
		amt = 32'(px.shade_amount);
		if (amt > 32'd65536) amt = 32'd65536;
		if (amt == 32'd0) begin
			o.red_out = px.red_in; o.green_out = px.green_in; o.blue_out = px.blue_in;
			return o;
		end
		case (px.role)
			hps_pkg::ROLE_TERRAIN_A: begin
				shift_k = 32'd0; grey_k = 32'd35499; sat_k = 32'd8456; drop_k = 32'd0;
			end
			hps_pkg::ROLE_TERRAIN_B: begin
				shift_k = 32'd789; grey_k = 32'd789; sat_k = 32'd10923; drop_k = 32'd7282;
			end
			default: begin
				shift_k = 32'd0; grey_k = 32'd0; sat_k = 32'd0; drop_k = 32'd0;
			end
		endcase
		mx = (r > g) ? r : g; if (b > mx) mx = b;
		mn = (r < g) ? r : g; if (b < mn) mn = b;
		d = mx - mn;
		v = (mx * 32'd65536 + 32'd127) / 32'd255;
		if (d == 32'd0) begin
			s = 32'd0; h = grey_k;
		end else begin
			if (r == mx) begin
				num = (g >= b) ? g - b : 32'd6 * d + g - b;
			end else if (g == mx) num = 32'd2 * d + b - r;
			else num = 32'd4 * d + r - g;
			h0 = ((num * 32'd65536 + 32'd3 * d) / (32'd6 * d)) & 32'hFFFF;
			s = (d * 32'd65536 + mx / 32'd2) / mx;
			h = (h0 + qmul(shift_k, amt)) & 32'hFFFF;
		end
		s = s + qmul(sat_k, amt);
		if (s > 32'd65536) s = 32'd65536;
		v = qmul(v, 32'd65536 - qmul(drop_k, amt));
		if (v > 32'd65536) v = 32'd65536;
		if (s == 32'd0) begin
			o.red_out = byte_of(v); o.green_out = byte_of(v); o.blue_out = byte_of(v);
			return o;
		end
		h6 = h * 32'd6; sec = h6 >> 16; f = h6 & 32'hFFFF;
		p = qmul(v, 32'd65536 - s);
		q = qmul(v, 32'd65536 - qmul(s, f));
		tt = qmul(v, 32'd65536 - qmul(s, 32'd65536 - f));
		case (sec)
			32'd0: begin x = v;  y = tt; z = p;  end
			32'd1: begin x = q;  y = v;  z = p;  end
			32'd2: begin x = p;  y = v;  z = tt; end
			32'd3: begin x = p;  y = q;  z = v;  end
			32'd4: begin x = tt; y = p;  z = v;  end
			default: begin x = v; y = p; z = q; end
		endcase
		o.red_out = byte_of(x); o.green_out = byte_of(y); o.blue_out = byte_of(z);
		return o;
	endfunction

	function void note_request(hps_pkg::pix_in_t px);
		pending.insert(pending.size(), shade(px));
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(hps_pkg::pix_out_t got);
		hps_pkg::pix_out_t want;
		checked++;
		if (pending.size() == 0) begin
			report("unexpected pixel", 0, 0);
			return;
		end
		want = pending.pop_front();
		if (got.red_out !== want.red_out)
			report("red", int'(got.red_out), int'(want.red_out));
		if (got.green_out !== want.green_out)
			report("green", int'(got.green_out), int'(want.green_out));
		if (got.blue_out !== want.blue_out)
			report("blue", int'(got.blue_out), int'(want.blue_out));
	endtask
endclass

module tb;

	localparam int LATENCY = 23;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	hps_pkg::pix_in_t src_pixel = '0;
	logic dst_valid;
	logic dst_ready = 1'b0;
	hps_pkg::pix_out_t dst_pixel;

	shade_board board = new();
	int sent;
	int idle_cycles;
	bit stim_done;

	hsv_pixel_shade_core dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_ready(src_ready), .src_pixel(src_pixel),
		.dst_valid(dst_valid), .dst_ready(dst_ready), .dst_pixel(dst_pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sample on the edge, before the nonblocking updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && src_ready) begin
				board.note_request(src_pixel);
				sent++;
			end
			if (dst_valid && dst_ready) board.check_result(dst_pixel);
			if ((src_valid && src_ready) || (dst_valid && dst_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress, %0d pixels outstanding", board.pending.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: own stall pattern, with calm stretches
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if ((phase / 300) % 3 == 0) dst_ready <= 1'b1;
			else dst_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_pixel(hps_pkg::pix_in_t px);
		src_valid <= 1'b1;
		src_pixel <= px;
		do @(posedge clk); while (!src_ready);
	endtask

	function automatic hps_pkg::pix_in_t rand_pixel();
		hps_pkg::pix_in_t px;
		int sel;
		px.red_in = 8'($urandom);
		px.green_in = 8'($urandom);
		px.blue_in = 8'($urandom);
		sel = $urandom_range(0, 9);
		if (sel == 0) px.green_in = px.red_in;
		if (sel == 1) begin px.green_in = px.red_in; px.blue_in = px.red_in; end
		if (sel == 2) px.blue_in = px.green_in;
		px.role = 2'($urandom_range(0, 3));
		sel = $urandom_range(0, 9);
		if (sel == 0) px.shade_amount = '0;
		else if (sel == 1) px.shade_amount = 17'd65536;
		else if (sel == 2) px.shade_amount = 17'($urandom_range(65537, 131071));
		else px.shade_amount = 17'($urandom_range(1, 65536));
		return px;
	endfunction

	initial begin
		hps_pkg::pix_in_t px;
		int n, gap;
		logic [7:0] lvl [4] = '{8'd0, 8'd1, 8'd128, 8'd255};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, greys, red/green/blue/yellow/violet, each role, amounts 0/1/max/over
		for (int k = 0; k < 24; k++) begin
			case (k % 8)
				0: px = '{8'd0, 8'd0, 8'd0, hps_pkg::ROLE_TERRAIN_A, 17'd0};
				1: px = '{8'd255, 8'd255, 8'd255, hps_pkg::ROLE_TERRAIN_A, 17'd65536};
				2: px = '{8'd255, 8'd0, 8'd0, hps_pkg::ROLE_TERRAIN_B, 17'd1};
				3: px = '{8'd0, 8'd255, 8'd0, hps_pkg::ROLE_EDGE, 17'd131071};
				4: px = '{8'd0, 8'd0, 8'd255, hps_pkg::ROLE_SPARE, 17'd65536};
				5: px = '{8'd255, 8'd255, 8'd1, hps_pkg::ROLE_TERRAIN_B, 17'd65536};
				6: px = '{lvl[k % 4], lvl[k % 4], lvl[k % 4], 2'(k % 3), 17'd32768};
				default: px = '{8'd128, 8'd0, 8'd255, hps_pkg::ROLE_TERRAIN_A, 17'd65535};
			endcase
			if (k >= 8) px.role = 2'(k / 8);
			send_pixel(px);
		end
		n = 0;
		while (n < 1550) begin
			int len;
			len = $urandom_range(1, 40);
			for (int j = 0; j < len; j++) begin
				send_pixel(rand_pixel());
				n++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		src_valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d pixels, %0d results checked", sent, board.checked);
		$display("all roles, greys, every hue sextant, zero/full/over-range amounts");
		if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== hsv_pixel_shade_core.f =====
rtl/core/hps_pkg.sv
rtl/core/hps_div_pipe.sv
rtl/core/hsv_pixel_shade_core.sv
tb/tb.sv
